// ===== design/rsrb_pkg.sv =====
// Shared types, codes and defaults of the run-length sprite row blitter.
`default_nettype none
package rsrb_pkg;

  // Default parameter values
  localparam int unsigned RemapFirstDef = 236;
  localparam int unsigned RemapLastDef  = 254;
  localparam int unsigned MaxColumnsDef = 4096;

  // Field widths
  localparam int unsigned ColW    = 13;  // internal source column
  localparam int unsigned DestW   = 12;  // destination offset
  localparam int unsigned ColorW  = 8;
  localparam int unsigned CntW    = 7;   // unique colors owed
  localparam int unsigned RepW    = 6;   // repeat count

  // Input command codes
  localparam logic [1:0] CmdRowStart = 2'd0;
  localparam logic [1:0] CmdControl  = 2'd1;
  localparam logic [1:0] CmdColor    = 2'd2;
  localparam logic [1:0] CmdRemap    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] RegFirstCol  = 2'd0;
  localparam logic [1:0] RegEndCol    = 2'd1;
  localparam logic [1:0] RegMirror    = 2'd2;
  localparam logic [1:0] RegSkipColor = 2'd3;

  // One pixel operation headed for the output stream
  typedef struct packed {
    logic [DestW-1:0]  dest_column;
    logic              action;
    logic [ColorW-1:0] pixel_color;
    logic [ColorW-1:0] remap_slot;
    logic              last_of_run;
  } pix_op_t;

endpackage
`default_nettype wire

// ===== design/rsrb_remap_mem.sv =====
// Remap-enable memory: 256 x 1, one write port, registered read.
`default_nettype none
module rsrb_remap_mem (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       we_i,
  input  wire logic       re_i,
  input  wire logic [7:0] addr_i,
  input  wire logic       wdata_i,
  output logic            rdata_o
);

  logic mem_q   [256];
  logic valid_q [256];
  logic rdata_q;

  // Entries never written read as disabled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 256; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (we_i) begin
      valid_q[addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= valid_q[addr_i] & mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== design/rsrb_out_reg.sv =====
// Output register: holds one pixel operation until the stream takes it.
`default_nettype none
module rsrb_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire rsrb_pkg::pix_op_t op_i,
  output logic                  free_o,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [31:0]           m_tdata,  // dest_column[11:0], pixel_color[19:12], remap_slot[27:20]
  output logic [0:0]            m_tuser,  // action[0]
  output logic                  m_tlast
);

  logic              valid_q;
  rsrb_pkg::pix_op_t op_q;

  assign free_o = !valid_q || m_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && free_o) begin
      op_q <= op_i;
    end
  end

  assign m_tvalid = valid_q;
  assign m_tdata  = {4'd0, op_q.remap_slot, op_q.pixel_color, op_q.dest_column};
  assign m_tuser  = op_q.action;
  assign m_tlast  = op_q.last_of_run;

endmodule
`default_nettype wire

// ===== design/rle_sprite_row_blit_top.sv =====
// Top level of the run-length sprite row blitter with clipping and mirroring.
// A color byte's transfer sets the run state; its first pixel operation is then registered
// in the output register, which drives m_tdata. Row start, control and remap-flag items are
// taken one per cycle; a color byte holds off the input until its pixels are issued, and a
// repeat color steps one column per cycle through the single output register while the
// output stream does not stall. Reset clears control state, registers and remap flags at once.
`default_nettype none
module rle_sprite_row_blit_top #(
  parameter int unsigned REMAP_FIRST = rsrb_pkg::RemapFirstDef,
  parameter int unsigned REMAP_LAST  = rsrb_pkg::RemapLastDef,
  parameter int unsigned MAX_COLUMNS = rsrb_pkg::MaxColumnsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB-style configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // command[1:0], data_byte[9:2], remap_flag[10]
  // Output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // dest_column[11:0], pixel_color[19:12], remap_slot[27:20]
  output logic [0:0]       m_tuser,  // action[0]
  output logic             m_tlast
);

  localparam int unsigned ColW = rsrb_pkg::ColW;

  localparam logic [16:0]     MaxCols    = 17'(MAX_COLUMNS);
  localparam logic [7:0]      RemapFirst = 8'(REMAP_FIRST);
  localparam logic [7:0]      RemapLast  = 8'(REMAP_LAST);
  localparam logic [ColW-1:0] ColSat     = {ColW{1'b1}};

  // Sequencer states
  localparam logic ST_IDLE = 1'b0;  // take the next item
  localparam logic ST_RUN  = 1'b1;  // flag read done, emit the color's pixels

  // What the next stream byte is expected to be
  localparam logic [1:0] EXP_CTRL   = 2'd0;
  localparam logic [1:0] EXP_UNIQUE = 2'd1;
  localparam logic [1:0] EXP_REPEAT = 2'd2;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [11:0]     first_col_q;
  logic [ColW-1:0] end_col_q;
  logic            mirror_q;
  logic [7:0]      skip_color_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_col_q  <= '0;
      end_col_q    <= '0;
      mirror_q     <= 1'b0;
      skip_color_q <= 8'hff;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        rsrb_pkg::RegFirstCol:  first_col_q  <= pwdata[11:0];
        rsrb_pkg::RegEndCol:    end_col_q    <= pwdata[ColW-1:0];
        rsrb_pkg::RegMirror:    mirror_q     <= pwdata[0];
        rsrb_pkg::RegSkipColor: skip_color_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      rsrb_pkg::RegFirstCol:  prdata = {20'd0, first_col_q};
      rsrb_pkg::RegEndCol:    prdata = {19'd0, end_col_q};
      rsrb_pkg::RegMirror:    prdata = {31'd0, mirror_q};
      rsrb_pkg::RegSkipColor: prdata = {24'd0, skip_color_q};
      default:                prdata = '0;
    endcase
  end

  // Clip end: end_col limited to the column capacity
  logic [ColW-1:0] win_end;
  assign win_end = ({4'd0, end_col_q} < MaxCols) ? end_col_q : MaxCols[ColW-1:0];

  // ---------------------------------------------------------------------------
  // Input transfer and remap-flag memory
  // ---------------------------------------------------------------------------
  logic       state_q;
  logic       in_xfer;
  logic [1:0] in_cmd;
  logic [7:0] in_byte;
  logic       in_flag;
  logic       remap_on;

  assign s_tready = (state_q == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign in_cmd   = s_tdata[1:0];
  assign in_byte  = s_tdata[9:2];
  assign in_flag  = s_tdata[10];

  // Flag writes and the color lookup both happen at the input transfer, so a
  // lookup always sees every earlier write; no forwarding path is needed.
  rsrb_remap_mem u_remap_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (in_xfer && (in_cmd == rsrb_pkg::CmdRemap)),
    .re_i    (in_xfer && (in_cmd == rsrb_pkg::CmdColor)),
    .addr_i  (in_byte),
    .wdata_i (in_flag),
    .rdata_o (remap_on)
  );

  // ---------------------------------------------------------------------------
  // Row sequencer
  // ---------------------------------------------------------------------------
  logic [ColW-1:0] col_q;
  logic [1:0]      expect_q;
  logic [6:0]      colors_left_q;
  logic [5:0]      rep_q;
  logic            row_done_q;
  logic [7:0]      color_q;

  logic [ColW-1:0] col_inc;
  logic [ColW:0]   skip_sum;
  logic [ColW-1:0] col_skip;
  logic            vis;
  logic            is_remap_color;
  logic            emit;
  logic            out_free;
  logic            step;
  logic            push;
  rsrb_pkg::pix_op_t op;

  assign col_inc  = (col_q == ColSat) ? col_q : col_q + 1'b1;
  assign skip_sum = {1'b0, col_q} + {8'd0, in_byte[5:0]};
  assign col_skip = (skip_sum > {1'b0, ColSat}) ? ColSat : skip_sum[ColW-1:0];

  assign vis            = (col_q >= {1'b0, first_col_q}) && (col_q < win_end);
  assign is_remap_color = (color_q >= RemapFirst);

  always_comb begin
    op = '0;
    if (expect_q == EXP_UNIQUE) begin
      // Transparent color drops; remap-range colors need their flag set
      emit      = vis && (color_q != skip_color_q) && (!is_remap_color || remap_on);
      op.action = is_remap_color;
      op.last_of_run = 1'b1;
    end else begin
      emit      = vis && (rep_q != '0);
      op.action = remap_on;
      // Visible columns are contiguous: mark the last of the run once the clip edge is next
      op.last_of_run = (rep_q == 6'd1) || ({1'b0, col_q} + 1'b1 >= {1'b0, win_end});
    end
    op.dest_column = mirror_q ? 12'(end_col_q - 1'b1 - col_q)
                              : 12'(col_q - {1'b0, first_col_q});
    op.pixel_color = op.action ? 8'd0 : color_q;
    op.remap_slot  = op.action ? RemapLast - color_q : 8'd0;
  end

  // Advance a column only when its pixel, if any, has a place to go
  assign step = (state_q == ST_RUN) && (!emit || out_free);
  assign push = (state_q == ST_RUN) && emit && out_free;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      color_q <= in_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      col_q         <= '0;
      expect_q      <= EXP_CTRL;
      colors_left_q <= '0;
      rep_q         <= '0;
      row_done_q    <= 1'b1;
    end else if (in_xfer) begin
      unique case (in_cmd)
        rsrb_pkg::CmdRowStart: begin
          col_q         <= '0;
          expect_q      <= EXP_CTRL;
          colors_left_q <= '0;
          rep_q         <= '0;
          row_done_q    <= (win_end == '0);
        end
        rsrb_pkg::CmdControl: begin
          // Drop control bytes past the row end or while colors are owed
          if (!row_done_q && (expect_q == EXP_CTRL)) begin
            if (!in_byte[7]) begin
              if (in_byte != 8'd0) begin
                colors_left_q <= in_byte[6:0];
                expect_q      <= EXP_UNIQUE;
              end
            end else if (in_byte[6]) begin
              col_q      <= col_skip;
              row_done_q <= (col_skip >= win_end);
            end else begin
              rep_q    <= in_byte[5:0];
              expect_q <= EXP_REPEAT;
            end
          end
        end
        rsrb_pkg::CmdColor: begin
          if (expect_q != EXP_CTRL) begin
            state_q <= ST_RUN;
          end
        end
        rsrb_pkg::CmdRemap: ;
        default: ;
      endcase
    end else if (step) begin
      if (expect_q == EXP_UNIQUE) begin
        col_q         <= col_inc;
        row_done_q    <= (col_inc >= win_end);
        colors_left_q <= colors_left_q - 1'b1;
        if (colors_left_q == 7'd1) begin
          expect_q <= EXP_CTRL;
        end
        state_q <= ST_IDLE;
      end else if (rep_q == '0) begin
        // Run finished (or empty): settle the row end and wait for control
        row_done_q <= (col_q >= win_end);
        expect_q   <= EXP_CTRL;
        state_q    <= ST_IDLE;
      end else begin
        col_q <= col_inc;
        rep_q <= rep_q - 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  rsrb_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .op_i     (op),
    .free_o   (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_run_after_color : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (in_cmd == rsrb_pkg::CmdColor) && (expect_q != EXP_CTRL))
      |=> (state_q == ST_RUN))
    else $error("color byte owed by a run did not start the emit phase");

  a_run_has_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (expect_q == EXP_UNIQUE || expect_q == EXP_REPEAT))
    else $error("emit phase without a unique or repeat run");

  a_push_visible : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (col_q < win_end) && (col_q >= {1'b0, first_col_q}))
    else $error("pixel operation issued outside the clip window");

  a_repeat_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && (expect_q == EXP_REPEAT) && (rep_q != '0))
      |=> (rep_q == $past(rep_q) - 1'b1))
    else $error("repeat count did not advance with its column");

endmodule
`default_nettype wire

// ===== verif/tb_rle_sprite_row_blit_top.sv =====
// Self-checking testbench for the run-length sprite row blitter.
`timescale 1ns / 100ps
`default_nettype none
module tb_rle_sprite_row_blit_top;

  localparam int unsigned RemapFirst   = rsrb_pkg::RemapFirstDef;
  localparam int unsigned RemapLast    = rsrb_pkg::RemapLastDef;
  localparam int unsigned MaxColumns   = rsrb_pkg::MaxColumnsDef;
  localparam int unsigned ColSat       = 8191;
  localparam int unsigned CycleLimit   = 1_000_000;
  // A repeat run of 63 columns keeps the block busy column by column even when
  // every column is clipped, so settle well past such a run before touching registers.
  localparam int unsigned SettleCycles = 100;
  localparam logic [7:0]  CtlSkipMax   = 8'hFF;

  // What the decoder wants next from the row stream.
  typedef enum logic [1:0] {
    WantControl     = 2'd0,
    WantColors      = 2'd1,
    WantRepeatColor = 2'd2
  } row_want_e;

  // Tracks the decoder state and the pixel operations still owed on m_*.
  class pixel_op_tracker;
    logic [11:0]  first_col;
    logic [12:0]  end_col;
    logic         mirror;
    logic [7:0]   skip_color;
    logic [12:0]  column;
    row_want_e    want;
    logic [6:0]   colors_left;
    logic [5:0]   repeat_count;
    logic         row_done;
    logic [255:0] remap_en;
    rsrb_pkg::pix_op_t owed_ops[$];
    int unsigned  errors;

    function new();
      first_col    = '0;
      end_col      = '0;
      mirror       = 1'b0;
      skip_color   = 8'hFF;
      column       = '0;
      want         = WantControl;
      colors_left  = '0;
      repeat_count = '0;
      row_done     = 1'b1;
      remap_en     = '0;
      errors       = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        rsrb_pkg::RegFirstCol:  first_col  = val[11:0];
        rsrb_pkg::RegEndCol:    end_col    = val[12:0];
        rsrb_pkg::RegMirror:    mirror     = val[0];
        rsrb_pkg::RegSkipColor: skip_color = val[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned win_end();
      return (32'(end_col) < MaxColumns) ? 32'(end_col) : MaxColumns;
    endfunction

    function bit visible(int unsigned c);
      return c >= 32'(first_col) && c < win_end();
    endfunction

    function void advance(int unsigned n);
      int unsigned sum;
      sum = 32'(column) + n;
      if (sum > ColSat) sum = ColSat;
      column   = sum[12:0];
      row_done = (32'(column) >= win_end());
    endfunction

    function rsrb_pkg::pix_op_t make_op(int unsigned c, logic act, logic [7:0] color);
      rsrb_pkg::pix_op_t op;
      int unsigned       d;
      int unsigned       slot;
      d    = mirror ? (32'(end_col) - 32'd1 - c) : (c - 32'(first_col));
      slot = RemapLast - 32'(color);
      op.dest_column = d[11:0];
      op.action      = act;
      op.pixel_color = act ? 8'd0 : color;
      op.remap_slot  = act ? slot[7:0] : 8'd0;
      op.last_of_run = 1'b0;
      return op;
    endfunction

    // Advance the decoder by one accepted stream byte and queue its pixel ops.
    function void take_stream_byte(logic [1:0] cmd, logic [7:0] b, logic flag);
      rsrb_pkg::pix_op_t burst[$];
      int unsigned       i;
      logic              act;
      case (cmd)
        rsrb_pkg::CmdRowStart: begin
          column       = '0;
          want         = WantControl;
          colors_left  = '0;
          repeat_count = '0;
          row_done     = (win_end() == 0);
        end
        rsrb_pkg::CmdRemap: remap_en[b] = flag;
        rsrb_pkg::CmdControl: begin
          if (!row_done && want == WantControl) begin
            if (!b[7]) begin
              if (b != 8'd0) begin
                colors_left = b[6:0];
                want        = WantColors;
              end
            end else if (b[6]) begin
              advance(32'(b[5:0]));
            end else begin
              repeat_count = b[5:0];
              want         = WantRepeatColor;
            end
          end
        end
        default: begin
          if (want == WantColors) begin
            if (visible(32'(column)) && b != skip_color) begin
              if (32'(b) < RemapFirst) begin
                burst.push_back(make_op(32'(column), 1'b0, b));
              end else if (remap_en[b]) begin
                burst.push_back(make_op(32'(column), 1'b1, b));
              end
            end
            advance(1);
            colors_left = colors_left - 7'd1;
            if (colors_left == 7'd0) want = WantControl;
          end else if (want == WantRepeatColor) begin
            act = remap_en[b];
            for (i = 0; i < 32'(repeat_count); i++) begin
              if (visible(32'(column) + i)) burst.push_back(make_op(32'(column) + i, act, b));
            end
            advance(32'(repeat_count));
            repeat_count = '0;
            want         = WantControl;
          end
        end
      endcase
      if (burst.size() > 0) burst[burst.size()-1].last_of_run = 1'b1;
      foreach (burst[k]) owed_ops.push_back(burst[k]);
    endfunction

    function void match_pixel_op(rsrb_pkg::pix_op_t got);
      rsrb_pkg::pix_op_t want_op;
      if (owed_ops.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel op col %0d act %0d color %0d slot %0d last %0d",
                 $time, got.dest_column, got.action, got.pixel_color, got.remap_slot,
                 got.last_of_run);
        return;
      end
      want_op = owed_ops.pop_front();
      if (got !== want_op) begin
        errors++;
        $display("%0t: pixel op mismatch, expected col %0d act %0d color %0d slot %0d last %0d",
                 $time, want_op.dest_column, want_op.action, want_op.pixel_color,
                 want_op.remap_slot, want_op.last_of_run);
        $display("%0t:                    actual   col %0d act %0d color %0d slot %0d last %0d",
                 $time, got.dest_column, got.action, got.pixel_color, got.remap_slot,
                 got.last_of_run);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // command[1:0], data_byte[9:2], remap_flag[10]
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // dest_column[11:0], pixel_color[19:12], remap_slot[27:20]
  logic [0:0]  m_tuser;   // action[0]
  logic        m_tlast;

  pixel_op_tracker tracker = new();

  int unsigned cycles;
  int unsigned items_left;   // stimulus budget of the current phase
  int unsigned hold_cycles;  // long sink hold-off requested by the sequencer
  int unsigned src_burst;
  int unsigned sink_burst;
  logic [7:0]  cur_skip;

  rle_sprite_row_blit_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Bound the run; a hung handshake ends here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sample both streams at the rising edge, before the block updates its outputs.
  // Feed accepted input bytes to the tracker first, then match any result transfer.
  always @(posedge clk_i) begin
    rsrb_pkg::pix_op_t got;
    if (rst_ni && s_tvalid && s_tready) begin
      tracker.take_stream_byte(s_tdata[1:0], s_tdata[9:2], s_tdata[10]);
    end
    if (rst_ni && m_tvalid && m_tready) begin
      got.dest_column = m_tdata[11:0];
      got.action      = m_tuser[0];
      got.pixel_color = m_tdata[19:12];
      got.remap_slot  = m_tdata[27:20];
      got.last_of_run = m_tlast;
      tracker.match_pixel_op(got);
    end
  end

  // Draw a random idle gap; now and then run a stretch with no idling.
  function automatic int unsigned draw_gap(inout int unsigned burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      burst = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // Result sink: stall at random per transfer, and honor a long hold-off when asked.
  initial begin
    int unsigned gap;
    m_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end
      gap = draw_gap(sink_burst);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      @(negedge clk_i);
    end
  end

  // Offer one stream byte after a random gap and hold it until the transfer.
  // Entered and left just after a falling edge; valid stays high across zero gaps.
  task automatic send_item(logic [1:0] cmd, logic [7:0] b, logic flag);
    int unsigned gap;
    gap = draw_gap(src_burst);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, flag, b, cmd};
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    if (items_left > 0) items_left--;
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, val);
  endtask

  task automatic apply_window(int unsigned first, int unsigned last_end, bit mir,
                              logic [7:0] skip);
    write_reg(rsrb_pkg::RegFirstCol, first);
    write_reg(rsrb_pkg::RegEndCol, last_end);
    write_reg(rsrb_pkg::RegMirror, 32'(mir));
    write_reg(rsrb_pkg::RegSkipColor, 32'(skip));
    cur_skip = skip;
  endtask

  // Drop the offer, drain every owed pixel op, then let a clipped repeat run finish.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (tracker.owed_ops.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Bias colors toward the transparent color and the remap range.
  function automatic logic [7:0] pick_color();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return cur_skip;
    if (r < 55) return 8'($urandom_range(RemapFirst, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  // One row: row start, long skips up to near the window, then a mix of
  // well-formed runs and some noise and broken runs.
  task automatic random_row(int unsigned first);
    int unsigned col;
    int unsigned target;
    int unsigned runs;
    int unsigned r;
    int unsigned len;
    int unsigned j;
    send_item(rsrb_pkg::CmdRowStart, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    col    = 0;
    target = (first > 20) ? first - $urandom_range(0, 20) : 0;
    while (col + 63 < target) begin
      send_item(rsrb_pkg::CmdControl, CtlSkipMax, 1'b0);
      col += 63;
    end
    runs = $urandom_range(2, 8);
    repeat (runs) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        // noise: any command, any byte
        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else if (r < 22) begin
        send_item(rsrb_pkg::CmdRemap,
                  8'(($urandom_range(0, 1) != 0) ? $urandom_range(RemapFirst, 255)
                                                 : $urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else if (r < 52) begin
        len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
        send_item(rsrb_pkg::CmdControl, len[7:0], 1'b0);
        for (j = 0; j < len; j++) begin
          // drop a color now and then to break the run
          if ($urandom_range(0, 19) != 0) send_item(rsrb_pkg::CmdColor, pick_color(), 1'b0);
        end
        col += len;
      end else if (r < 70) begin
        len = $urandom_range(0, 63);
        send_item(rsrb_pkg::CmdControl, 8'hC0 | len[7:0], 1'b0);
        col += len;
      end else begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
        send_item(rsrb_pkg::CmdControl, 8'h80 | len[7:0], 1'b0);
        send_item(rsrb_pkg::CmdColor, pick_color(), 1'b0);
        col += len;
      end
    end
  endtask

  task automatic run_phase(int unsigned first, int unsigned last_end, bit mir,
                           logic [7:0] skip, int unsigned budget, int unsigned hold);
    apply_window(first, last_end, mir, skip);
    hold_cycles = hold;
    items_left  = budget;
    while (items_left > 0) random_row(first);
    settle();
  endtask

  initial begin
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    cycles      = 0;
    items_left  = 0;
    hold_cycles = 0;
    src_burst   = 0;
    sink_burst  = 0;
    cur_skip    = 8'hFF;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed row over the full window.
    apply_window(0, MaxColumns, 1'b0, 8'hFF);
    send_item(rsrb_pkg::CmdRemap, 8'd240, 1'b1);
    send_item(rsrb_pkg::CmdRemap, 8'd255, 1'b1);
    send_item(rsrb_pkg::CmdRemap, 8'd254, 1'b1);
    send_item(rsrb_pkg::CmdColor, 8'h12, 1'b0);      // color while a control byte is due
    send_item(rsrb_pkg::CmdRowStart, 8'h00, 1'b0);
    send_item(rsrb_pkg::CmdControl, 8'h00, 1'b0);    // empty unique run consumes nothing
    send_item(rsrb_pkg::CmdControl, 8'h05, 1'b0);
    send_item(rsrb_pkg::CmdColor, 8'd0, 1'b0);       // plain write
    send_item(rsrb_pkg::CmdColor, 8'd255, 1'b0);     // transparent, flag set or not
    send_item(rsrb_pkg::CmdColor, 8'd235, 1'b0);     // last color below the remap range
    send_item(rsrb_pkg::CmdColor, 8'd236, 1'b0);     // remap range, flag clear: nothing
    send_item(rsrb_pkg::CmdColor, 8'd240, 1'b0);     // remap range, flag set: remap op
    send_item(rsrb_pkg::CmdControl, 8'h03, 1'b0);
    send_item(rsrb_pkg::CmdColor, 8'd255, 1'b0);
    send_item(rsrb_pkg::CmdControl, 8'h81, 1'b0);    // control while colors are owed
    send_item(rsrb_pkg::CmdColor, 8'd254, 1'b0);     // remap slot zero
    send_item(rsrb_pkg::CmdColor, 8'd12, 1'b0);
    send_item(rsrb_pkg::CmdControl, 8'hC5, 1'b0);    // skip run
    send_item(rsrb_pkg::CmdControl, 8'h80, 1'b0);    // empty repeat run still eats its color
    send_item(rsrb_pkg::CmdColor, 8'd7, 1'b0);
    send_item(rsrb_pkg::CmdControl, 8'hBF, 1'b0);    // longest repeat run, remapped
    send_item(rsrb_pkg::CmdColor, 8'd240, 1'b0);
    send_item(rsrb_pkg::CmdControl, 8'h82, 1'b0);    // repeat of 255: no transparency
    send_item(rsrb_pkg::CmdColor, 8'd255, 1'b0);
    settle();

    // Random phases over a spread of windows, extremes included.
    run_phase(10, 60, 1'b1, 8'h00, 1, 0);
    run_phase(0, MaxColumns, 1'b1, 8'h80, 12, 400);  // long sink hold-off fills the block
    run_phase(4095, MaxColumns, 1'b0, 8'h55, 1, 0);  // only the last column is visible
    run_phase(0, 0, 1'b0, 8'hAA, 1, 0);              // empty window
    run_phase(100, 50, 1'b1, 8'h00, 1, 0);           // inverted window
    run_phase(5, 40, 1'b0, 8'd236, 1, 0);

    settle();
    if (tracker.errors == 0 && tracker.owed_ops.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
